// ===== rtl/voxel_sphere_rasterizer_defines.svh =====
// Assertion macros shared by the voxel sphere rasterizer RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef VOXEL_SPHERE_RASTERIZER_DEFINES_SVH
`define VOXEL_SPHERE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vsr_pkg.sv =====
// Package for the voxel sphere rasterizer: sizes, command codes,
// controller states and the controller/datapath command and status words.
`default_nettype none
package vsr_pkg;

  localparam int SIDE       = 8;
  localparam int CW         = 3;            // bits of one coordinate
  localparam int VOXELS     = SIDE * SIDE * SIDE;
  localparam int VW         = 9;            // bits of a voxel address
  localparam int ROOT_STEPS = 13;           // result bits of the square root

  typedef enum logic [1:0] {
    CMD_DRAW = 2'd0,
    CMD_FILL = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } vsr_cmd_code_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SETUP,
    ST_SQ,
    ST_SUM,
    ST_CHK,
    ST_ROOT,
    ST_BRT,
    ST_SCALE,
    ST_WR,
    ST_RD,
    ST_DONE
  } vsr_state_t;

  typedef struct packed {
    logic latch;      // capture the input word
    logic cnt_clr;
    logic cnt_inc;
    logic setup;      // radius squares
    logic sq;         // offset squares
    logic sum;        // squared distance
    logic root_init;
    logic root_step;
    logic brt;
    logic scale;
    logic wr_en;
    logic wr_draw;    // write accumulated draw data
    logic wr_zero;    // write zero color
    logic load_out;
  } vsr_ctl_t;

  typedef struct packed {
    logic last;       // voxel counter at the final voxel
    logic skip;       // voxel outside radius + 1
    logic inner;      // voxel inside radius
    logic root_last;
  } vsr_sts_t;

endpackage
`default_nettype wire

// ===== rtl/vsr_in_if.sv =====
// Input channel of the voxel sphere rasterizer: valid/ready and one command word.
// Depends on nothing.
`default_nettype none
interface vsr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [8:0] center_x;
  logic signed [8:0] center_y;
  logic signed [8:0] center_z;
  logic [7:0]        radius;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic [8:0]        voxel_index;

  modport source (output valid, cmd, center_x, center_y, center_z, radius,
                  red, green, blue, voxel_index, input ready);
  modport sink   (input valid, cmd, center_x, center_y, center_z, radius,
                  red, green, blue, voxel_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/vsr_out_if.sv =====
// Result channel of the voxel sphere rasterizer: valid/ready and one color word.
// Depends on nothing.
`default_nettype none
interface vsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/vsr_datapath.sv =====
// Datapath: frame store memory, voxel counter, distance, square root,
// brightness and accumulation. Depends on vsr_pkg; driven by vsr_ctrl.
`default_nettype none
module vsr_datapath (
  input  wire logic              clk,
  input  wire vsr_pkg::vsr_ctl_t ctl,
  output vsr_pkg::vsr_sts_t      sts,
  input  wire logic [1:0]        in_cmd,
  input  wire logic signed [8:0] in_cx,
  input  wire logic signed [8:0] in_cy,
  input  wire logic signed [8:0] in_cz,
  input  wire logic [7:0]        in_rad,
  input  wire logic [7:0]        in_r,
  input  wire logic [7:0]        in_g,
  input  wire logic [7:0]        in_b,
  input  wire logic [8:0]        in_idx,
  input  wire logic              rst_n,
  output logic [7:0]             out_r,
  output logic [7:0]             out_g,
  output logic [7:0]             out_b
);

  logic [23:0] mem [vsr_pkg::VOXELS];

  logic [1:0]        cmd_r;
  logic signed [8:0] cx_r, cy_r, cz_r;
  logic [7:0]        rad_r, r_r, g_r, b_r;
  logic [8:0]        idx_r;
  logic [vsr_pkg::VW:0] cnt_r;
  logic [15:0]       rsq_r;
  logic [16:0]       outer_r;
  logic [17:0]       sqx_r, sqy_r, sqz_r;
  logic [19:0]       dsq_r;
  logic [25:0]       v_r;
  logic [15:0]       rem_r;
  logic [12:0]       q_r;
  logic [3:0]        root_cnt_r;
  logic [7:0]        bright_r;
  logic [7:0]        sr_r, sg_r, sb_r;
  logic [23:0]       rd_r;
  logic [7:0]        out_r_r, out_g_r, out_b_r;

  logic [vsr_pkg::CW-1:0] x, y, z, col, row;
  logic [vsr_pkg::VW-1:0] wire_idx, rd_addr, wr_addr;
  logic signed [9:0]      dx, dy, dz;
  logic [8:0]             rad16;
  logic [15:0]            rem_sh, trial;
  logic [11:0]            base;
  logic [12:0]            t13;
  logic [8:0]             t;
  logic [16:0]            m;
  logic [8:0]             b9;
  logic [8:0]             bp1;
  logic [16:0]            pr, pg, pb;
  logic [8:0]             ar, ag, ab;
  logic [23:0]            wr_data;

  assign x = cnt_r[3*vsr_pkg::CW-1:2*vsr_pkg::CW];
  assign y = cnt_r[2*vsr_pkg::CW-1:vsr_pkg::CW];
  assign z = cnt_r[vsr_pkg::CW-1:0];

  // serpentine wiring: rows flip on odd layers, columns on odd row parity
  always_comb begin
    col = ((z[0] ^ y[0]) == 1'b0) ? x : 3'(vsr_pkg::SIDE - 1) - x;
    row = (y[0] == 1'b0) ? z : 3'(vsr_pkg::SIDE - 1) - z;
    wire_idx = {y, row, col};
  end

  assign rd_addr = (cmd_r == vsr_pkg::CMD_READ) ? idx_r : wire_idx;
  assign wr_addr = ctl.wr_draw ? wire_idx : cnt_r[vsr_pkg::VW-1:0];

  assign dx = {cx_r[8], cx_r} - $signed({3'b000, x, 4'b0000});
  assign dy = {cy_r[8], cy_r} - $signed({3'b000, y, 4'b0000});
  assign dz = {cz_r[8], cz_r} - $signed({3'b000, z, 4'b0000});
  assign rad16 = {1'b0, rad_r} + 9'd16;

  assign rem_sh = {rem_r[13:0], v_r[25:24]};
  assign trial  = {1'b0, q_r, 2'b01};

  always_comb begin
    base = {rad_r, 4'b0000};
    t13  = (q_r > {1'b0, base}) ? q_r - {1'b0, base} : 13'd0;
    t    = (t13 > 13'd256) ? 9'd256 : t13[8:0];
    m    = {t, 8'b0} - {8'b0, t} + 17'd255;
    b9   = 9'd256 - {1'b0, m[15:8]};
  end

  assign bp1 = {1'b0, bright_r} + 9'd1;
  assign pr  = r_r * bp1;
  assign pg  = g_r * bp1;
  assign pb  = b_r * bp1;

  assign ar = {1'b0, rd_r[23:16]} + {1'b0, sr_r};
  assign ag = {1'b0, rd_r[15:8]}  + {1'b0, sg_r};
  assign ab = {1'b0, rd_r[7:0]}   + {1'b0, sb_r};

  always_comb begin
    if (ctl.wr_draw) begin
      wr_data = {ar[8] ? 8'hFF : ar[7:0], ag[8] ? 8'hFF : ag[7:0],
                 ab[8] ? 8'hFF : ab[7:0]};
    end else if (ctl.wr_zero) begin
      wr_data = '0;
    end else begin
      wr_data = {r_r, g_r, b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.cnt_clr) begin
      cnt_r <= '0;
    end else if (ctl.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r <= in_cmd;
      cx_r  <= in_cx;
      cy_r  <= in_cy;
      cz_r  <= in_cz;
      rad_r <= in_rad;
      r_r   <= in_r;
      g_r   <= in_g;
      b_r   <= in_b;
      idx_r <= in_idx;
    end
    if (ctl.setup) begin
      rsq_r   <= rad_r * rad_r;
      outer_r <= 17'(rad16 * rad16);
    end
    if (ctl.sq) begin
      sqx_r <= 18'(dx * dx);
      sqy_r <= 18'(dy * dy);
      sqz_r <= 18'(dz * dz);
    end
    if (ctl.sum) begin
      dsq_r <= {2'b0, sqx_r} + {2'b0, sqy_r} + {2'b0, sqz_r};
    end
    if (ctl.root_init) begin
      v_r        <= {1'b0, dsq_r[16:0], 8'b0};
      rem_r      <= '0;
      q_r        <= '0;
      root_cnt_r <= 4'(vsr_pkg::ROOT_STEPS - 1);
    end else if (ctl.root_step) begin
      v_r        <= {v_r[23:0], 2'b00};
      root_cnt_r <= root_cnt_r - 1'b1;
      if (rem_sh >= trial) begin
        rem_r <= rem_sh - trial;
        q_r   <= {q_r[11:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[11:0], 1'b0};
      end
    end
    if (ctl.brt) begin
      if (sts.inner || b9 > 9'd255) begin
        bright_r <= 8'd255;
      end else begin
        bright_r <= b9[7:0];
      end
    end
    if (ctl.scale) begin
      sr_r <= pr[15:8];
      sg_r <= pg[15:8];
      sb_r <= pb[15:8];
    end
    if (ctl.load_out) begin
      if (cmd_r == vsr_pkg::CMD_READ && {1'b0, idx_r} < 10'(vsr_pkg::VOXELS)) begin
        out_r_r <= rd_r[23:16];
        out_g_r <= rd_r[15:8];
        out_b_r <= rd_r[7:0];
      end else begin
        out_r_r <= '0;
        out_g_r <= '0;
        out_b_r <= '0;
      end
    end
  end

  assign sts.last      = (cnt_r == (vsr_pkg::VW+1)'(vsr_pkg::VOXELS - 1));
  assign sts.skip      = (dsq_r > {3'b0, outer_r});
  assign sts.inner     = (dsq_r <= {4'b0, rsq_r});
  assign sts.root_last = (root_cnt_r == 4'd0);

  assign out_r = out_r_r;
  assign out_g = out_g_r;
  assign out_b = out_b_r;

endmodule
`default_nettype wire

// ===== rtl/vsr_ctrl.sv =====
// Controller state machine: sequences clear, fill, draw and read commands
// and owns the result valid flag. Depends on vsr_pkg and the defines header.
`default_nettype none
`include "voxel_sphere_rasterizer_defines.svh"
module vsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_cmd,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vsr_pkg::vsr_ctl_t      ctl,
  input  wire vsr_pkg::vsr_sts_t sts
);

  vsr_pkg::vsr_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vsr_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      vsr_pkg::ST_CLEAR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_zero = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (sts.last) begin
          state_nxt = vsr_pkg::ST_IDLE;
        end
      end
      vsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch   = 1'b1;
          ctl.cnt_clr = 1'b1;
          case (vsr_pkg::vsr_cmd_code_t'(in_cmd))
            vsr_pkg::CMD_DRAW: state_nxt = vsr_pkg::ST_SETUP;
            vsr_pkg::CMD_FILL: state_nxt = vsr_pkg::ST_FILL;
            vsr_pkg::CMD_READ: state_nxt = vsr_pkg::ST_RD;
            default:           state_nxt = vsr_pkg::ST_DONE;
          endcase
        end
      end
      vsr_pkg::ST_FILL: begin
        ctl.wr_en   = 1'b1;
        ctl.cnt_inc = 1'b1;
        if (sts.last) begin
          state_nxt = vsr_pkg::ST_DONE;
        end
      end
      vsr_pkg::ST_SETUP: begin
        ctl.setup = 1'b1;
        state_nxt = vsr_pkg::ST_SQ;
      end
      vsr_pkg::ST_SQ: begin
        ctl.sq    = 1'b1;
        state_nxt = vsr_pkg::ST_SUM;
      end
      vsr_pkg::ST_SUM: begin
        ctl.sum   = 1'b1;
        state_nxt = vsr_pkg::ST_CHK;
      end
      vsr_pkg::ST_CHK: begin
        ctl.root_init = 1'b1;
        if (sts.skip) begin
          if (sts.last) begin
            state_nxt = vsr_pkg::ST_DONE;
          end else begin
            ctl.cnt_inc = 1'b1;
            state_nxt   = vsr_pkg::ST_SQ;
          end
        end else if (sts.inner) begin
          state_nxt = vsr_pkg::ST_BRT;
        end else begin
          state_nxt = vsr_pkg::ST_ROOT;
        end
      end
      vsr_pkg::ST_ROOT: begin
        ctl.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = vsr_pkg::ST_BRT;
        end
      end
      vsr_pkg::ST_BRT: begin
        ctl.brt   = 1'b1;
        state_nxt = vsr_pkg::ST_SCALE;
      end
      vsr_pkg::ST_SCALE: begin
        ctl.scale = 1'b1;
        state_nxt = vsr_pkg::ST_WR;
      end
      vsr_pkg::ST_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_draw = 1'b1;
        if (sts.last) begin
          state_nxt = vsr_pkg::ST_DONE;
        end else begin
          ctl.cnt_inc = 1'b1;
          state_nxt   = vsr_pkg::ST_SQ;
        end
      end
      vsr_pkg::ST_RD: begin
        state_nxt = vsr_pkg::ST_DONE;
      end
      vsr_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          ctl.load_out = 1'b1;
          state_nxt    = vsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `VSR_ASSERT_NEXT(a_clear_once, state_r != vsr_pkg::ST_CLEAR, state_r != vsr_pkg::ST_CLEAR, "clear pass re-entered")
  `VSR_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !ctl.load_out, "pending result overwritten")
  `VSR_ASSERT_NEXT(a_root_entry, state_r != vsr_pkg::ST_CHK && state_r != vsr_pkg::ST_ROOT, state_r != vsr_pkg::ST_ROOT, "square root entered without distance check")

endmodule
`default_nettype wire

// ===== rtl/voxel_sphere_rasterizer.sv =====
// Top level of the voxel sphere rasterizer: joins the controller and the
// datapath to the channel interfaces. Depends on vsr_pkg, vsr_in_if, vsr_out_if.
//
//   channel   dir   word                                       handshake
//   in_ch     in    cmd, center_x/y/z, radius, red/green/blue,  valid/ready
//                   voxel_index
//   out_ch    out   out_red, out_green, out_blue                valid/ready
//
// One word at a time. Fill walks all 512 voxels; read passes ST_RD.
// Draw walks all 512 voxels: ST_SQ, ST_SUM, ST_CHK for a voxel beyond
// radius + 1; also ST_BRT, ST_SCALE, ST_WR inside the radius; in the rim
// also the 13-step square root unit in ST_ROOT; plus ST_SETUP and ST_DONE.
// Reset: a clearing pass over all 512 voxels zeroes the frame store; no word is
// taken meanwhile. A stalled result holds in the output register while the
// next word is accepted; the block then waits before posting its own result.
`default_nettype none
module voxel_sphere_rasterizer (
  input wire logic clk,
  input wire logic rst_n,
  vsr_in_if.sink   in_ch,
  vsr_out_if.source out_ch
);

  vsr_pkg::vsr_ctl_t ctl;
  vsr_pkg::vsr_sts_t sts;

  vsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  vsr_datapath u_dp (
    .clk    (clk),
    .ctl    (ctl),
    .sts    (sts),
    .in_cmd (in_ch.cmd),
    .in_cx  (in_ch.center_x),
    .in_cy  (in_ch.center_y),
    .in_cz  (in_ch.center_z),
    .in_rad (in_ch.radius),
    .in_r   (in_ch.red),
    .in_g   (in_ch.green),
    .in_b   (in_ch.blue),
    .in_idx (in_ch.voxel_index),
    .rst_n  (rst_n),
    .out_r  (out_ch.out_red),
    .out_g  (out_ch.out_green),
    .out_b  (out_ch.out_blue)
  );

endmodule
`default_nettype wire
